// ===== design/assert_macros.svh =====
// assertion macros shared by the ray versus cylinder design
// needs clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME_CYCLE(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rci_pkg.sv =====
// shared types, constants and saturating fixed point helpers for the
// ray versus cylinder pipeline; no dependencies
package rci_pkg;

    localparam int FRAC_BITS = 16;

    // wide signed width used for exact intermediate sums
    localparam int SW = 66;
    // width of a product after the fraction shift
    localparam int PW = 64 - FRAC_BITS;

    // square root unit: two root bits per stage
    localparam int SQRT_ROOT_W = 2 * ((31 + FRAC_BITS + 3) / 4);
    localparam int SQRT_RAD_W  = 2 * SQRT_ROOT_W;
    localparam int SQRT_STAGES = SQRT_ROOT_W / 2;

    // divider: two quotient bits per stage
    localparam int DIV_STAGES = (32 + FRAC_BITS + 1) / 2;
    localparam int DIV_N_W    = 2 * DIV_STAGES;

    typedef logic signed [31:0] word_t;
    typedef logic signed [17:0] axis_t;

    typedef enum logic [2:0] {
        REG_AXIS_X   = 3'd0,
        REG_AXIS_Y   = 3'd1,
        REG_AXIS_Z   = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_CENTER_Z = 3'd5,
        REG_RADIUS_SQ = 3'd6
    } reg_index_t;

    typedef struct packed {
        word_t ox;
        word_t oy;
        word_t oz;
        word_t dx;
        word_t dy;
        word_t dz;
        word_t tlo;
        word_t thi;
    } ray_t;

    typedef struct packed {
        axis_t       ax;
        axis_t       ay;
        axis_t       az;
        word_t       cx;
        word_t       cy;
        word_t       cz;
        logic [30:0] r2;
    } cfg_t;

    typedef struct packed {
        ray_t  ray;
        word_t ocv;
        word_t nb;
        word_t den;
        logic  noroot;
    } quad_t;

    typedef struct packed {
        ray_t  ray;
        word_t ocv;
        word_t t;
        logic  hit;
    } sel_t;

    typedef struct packed {
        logic  hit;
        word_t t;
        word_t px;
        word_t py;
        word_t pz;
        word_t nx;
        word_t ny;
        word_t nz;
    } surf_t;

    localparam logic signed [SW-1:0] W_MAX = SW'(2147483647);
    localparam logic signed [SW-1:0] W_MIN = -W_MAX - 1;
    localparam logic signed [SW-1:0] N_MAX = SW'(131071);
    localparam logic signed [SW-1:0] N_MIN = -N_MAX - 1;

    function automatic logic signed [SW-1:0] wide(input word_t x);
        return SW'(x);
    endfunction

    function automatic word_t sat32(input logic signed [SW-1:0] v);
        if (v > W_MAX) begin
            return word_t'(W_MAX);
        end
        if (v < W_MIN) begin
            return word_t'(W_MIN);
        end
        return word_t'(v);
    endfunction

    function automatic axis_t clamp18(input logic signed [SW-1:0] v);
        if (v > N_MAX) begin
            return axis_t'(N_MAX);
        end
        if (v < N_MIN) begin
            return axis_t'(N_MIN);
        end
        return axis_t'(v);
    endfunction

    function automatic word_t axis_w(input axis_t a);
        return word_t'(a);
    endfunction

    function automatic word_t add_sat(input word_t a, input word_t b);
        return sat32(wide(a) + wide(b));
    endfunction

    function automatic word_t sub_sat(input word_t a, input word_t b);
        return sat32(wide(a) - wide(b));
    endfunction

    function automatic word_t dbl_sat(input word_t a);
        return sat32(wide(a) <<< 1);
    endfunction

    function automatic word_t quad_sat(input word_t a);
        return sat32(wide(a) <<< 2);
    endfunction

    function automatic word_t neg_sat(input word_t a);
        return sat32(-wide(a));
    endfunction

    // exact product, floor shifted by the fraction bits
    function automatic logic signed [PW-1:0] pshift(input word_t a, input word_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return PW'(p >>> FRAC_BITS);
    endfunction

    function automatic word_t fmul(input word_t a, input word_t b);
        return sat32(SW'(pshift(a, b)));
    endfunction

    function automatic word_t dot3(input logic signed [PW-1:0] p0,
                                   input logic signed [PW-1:0] p1,
                                   input logic signed [PW-1:0] p2);
        return sat32(SW'(p0) + SW'(p1) + SW'(p2));
    endfunction

    // square root unit takes zero for non-positive words
    function automatic logic [30:0] sqrt_arg(input word_t x);
        return (x > 0) ? x[30:0] : 31'd0;
    endfunction

    function automatic logic signed [SW-1:0] quot_signed(input logic [DIV_N_W-1:0] q,
                                                         input logic neg);
        logic signed [SW-1:0] v;
        v = $signed(SW'(q));
        return neg ? -v : v;
    endfunction

endpackage

// ===== design/rci_sqrt_pipe.sv =====
// pipelined restoring square root, floor(sqrt(arg << FRAC_BITS))
// depends on rci_pkg; two root bits resolved per stage
module rci_sqrt_pipe (
    input  logic                             clk,
    input  logic                             en,
    input  logic [30:0]                      arg,
    output logic [rci_pkg::SQRT_ROOT_W-1:0]  root
);

    localparam int RW = rci_pkg::SQRT_ROOT_W;
    localparam int AW = rci_pkg::SQRT_RAD_W;
    localparam int NS = rci_pkg::SQRT_STAGES;

    typedef struct packed {
        logic [RW+1:0] rem;
        logic [RW-1:0] root;
        logic [AW-1:0] rad;
    } sq_t;

    function automatic sq_t sq_step(input sq_t s_in);
        logic [RW+1:0] rem;
        logic [RW+1:0] trial;
        sq_t           s;
        s = s_in;
        for (int i = 0; i < 2; i++) begin
            rem   = {s.rem[RW-1:0], s.rad[AW-1 -: 2]};
            s.rad = s.rad << 2;
            trial = {s.root, 2'b01};
            if (rem >= trial) begin
                s.rem  = rem - trial;
                s.root = {s.root[RW-2:0], 1'b1};
            end
            else begin
                s.rem  = rem;
                s.root = {s.root[RW-2:0], 1'b0};
            end
        end
        return s;
    endfunction

    sq_t init;
    sq_t st_reg [NS];

    always_comb
    begin
        init.rem  = '0;
        init.root = '0;
        init.rad  = AW'({arg, {rci_pkg::FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= sq_step(init);
            for (int i = 1; i < NS; i++) begin
                st_reg[i] <= sq_step(st_reg[i-1]);
            end
        end
    end

    assign root = st_reg[NS-1].root;

endmodule

// ===== design/rci_div_pipe.sv =====
// pipelined restoring divider, (|num| << FRAC_BITS) / |den| with sign
// depends on rci_pkg; two quotient bits resolved per stage
module rci_div_pipe (
    input  logic                         clk,
    input  logic                         en,
    input  rci_pkg::word_t               num,
    input  rci_pkg::word_t               den,
    output logic [rci_pkg::DIV_N_W-1:0]  quot,
    output logic                         neg
);

    localparam int QW = rci_pkg::DIV_N_W;
    localparam int NS = rci_pkg::DIV_STAGES;

    typedef struct packed {
        logic [32:0]   rem;
        logic [QW-1:0] qd;   // dividend shifts out on top, quotient in at bottom
        logic [31:0]   dsr;
        logic          neg;
    } dv_t;

    function automatic dv_t dv_step(input dv_t s_in);
        logic [32:0] rem;
        dv_t         s;
        s = s_in;
        for (int i = 0; i < 2; i++) begin
            rem  = {s.rem[31:0], s.qd[QW-1]};
            s.qd = s.qd << 1;
            if (rem >= {1'b0, s.dsr}) begin
                s.rem   = rem - {1'b0, s.dsr};
                s.qd[0] = 1'b1;
            end
            else begin
                s.rem = rem;
            end
        end
        return s;
    endfunction

    dv_t         init;
    dv_t         st_reg [NS];
    logic [31:0] abs_num;

    always_comb
    begin
        abs_num  = num[31] ? (~num + 32'd1) : num;
        init.rem = '0;
        init.qd  = QW'({abs_num, {rci_pkg::FRAC_BITS{1'b0}}});
        init.dsr = den[31] ? (~den + 32'd1) : den;
        init.neg = num[31] ^ den[31];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= dv_step(init);
            for (int i = 1; i < NS; i++) begin
                st_reg[i] <= dv_step(st_reg[i-1]);
            end
        end
    end

    assign quot = st_reg[NS-1].qd;
    assign neg  = st_reg[NS-1].neg;

endmodule

// ===== design/rci_quad.sv =====
// seven stage front end: builds a, b, c of the quadratic and its
// discriminant for one ray per cycle while en is high; depends on rci_pkg
module rci_quad (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rci_pkg::ray_t   ray,
    input  rci_pkg::cfg_t   cfg,
    output logic            out_valid,
    output rci_pkg::quad_t  quad,
    output rci_pkg::word_t  disc
);

    localparam int NS = 7;

    logic [NS-1:0]  v_reg;
    rci_pkg::ray_t  ray_reg [NS];
    rci_pkg::word_t axv [3];
    rci_pkg::word_t cv [3];
    rci_pkg::word_t oin [3];
    rci_pkg::word_t d1 [3];
    rci_pkg::word_t oc1_reg [3];
    logic signed [rci_pkg::PW-1:0] pdv_reg [3];
    logic signed [rci_pkg::PW-1:0] pocv_reg [3];
    logic signed [rci_pkg::PW-1:0] pdd_reg [3];
    logic signed [rci_pkg::PW-1:0] pdoc_reg [3];
    logic signed [rci_pkg::PW-1:0] pococ_reg [3];
    rci_pkg::word_t dv3_reg, ocv3_reg, dd3_reg, doc3_reg, ococ3_reg;
    rci_pkg::word_t dvdv4_reg, dvocv4_reg, ocvocv4_reg;
    rci_pkg::word_t ocv4_reg, dd4_reg, doc4_reg, ococ4_reg;
    rci_pkg::word_t a5_reg, b5_reg, c5_reg, ocv5_reg;
    rci_pkg::word_t bb6_reg, ac6_reg, a6_reg, b6_reg, ocv6_reg;
    rci_pkg::word_t disc_next;
    rci_pkg::word_t disc7_reg, den7_reg, nb7_reg, ocv7_reg;
    logic           noroot7_reg;

    always_comb
    begin
        axv[0]    = rci_pkg::axis_w(cfg.ax);
        axv[1]    = rci_pkg::axis_w(cfg.ay);
        axv[2]    = rci_pkg::axis_w(cfg.az);
        cv[0]     = cfg.cx;
        cv[1]     = cfg.cy;
        cv[2]     = cfg.cz;
        oin[0]    = ray.ox;
        oin[1]    = ray.oy;
        oin[2]    = ray.oz;
        d1[0]     = ray_reg[0].dx;
        d1[1]     = ray_reg[0].dy;
        d1[2]     = ray_reg[0].dz;
        disc_next = rci_pkg::sub_sat(bb6_reg, rci_pkg::quad_sat(ac6_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray_reg[0] <= ray;
            for (int i = 1; i < NS; i++) begin
                ray_reg[i] <= ray_reg[i-1];
            end
            // offset from the axis point
            for (int k = 0; k < 3; k++) begin
                oc1_reg[k] <= rci_pkg::sub_sat(oin[k], cv[k]);
            end
            // all products of the dot terms
            for (int k = 0; k < 3; k++) begin
                pdv_reg[k]   <= rci_pkg::pshift(d1[k], axv[k]);
                pocv_reg[k]  <= rci_pkg::pshift(oc1_reg[k], axv[k]);
                pdd_reg[k]   <= rci_pkg::pshift(d1[k], d1[k]);
                pdoc_reg[k]  <= rci_pkg::pshift(d1[k], oc1_reg[k]);
                pococ_reg[k] <= rci_pkg::pshift(oc1_reg[k], oc1_reg[k]);
            end
            dv3_reg   <= rci_pkg::dot3(pdv_reg[0], pdv_reg[1], pdv_reg[2]);
            ocv3_reg  <= rci_pkg::dot3(pocv_reg[0], pocv_reg[1], pocv_reg[2]);
            dd3_reg   <= rci_pkg::dot3(pdd_reg[0], pdd_reg[1], pdd_reg[2]);
            doc3_reg  <= rci_pkg::dot3(pdoc_reg[0], pdoc_reg[1], pdoc_reg[2]);
            ococ3_reg <= rci_pkg::dot3(pococ_reg[0], pococ_reg[1], pococ_reg[2]);

            dvdv4_reg   <= rci_pkg::fmul(dv3_reg, dv3_reg);
            dvocv4_reg  <= rci_pkg::fmul(dv3_reg, ocv3_reg);
            ocvocv4_reg <= rci_pkg::fmul(ocv3_reg, ocv3_reg);
            ocv4_reg    <= ocv3_reg;
            dd4_reg     <= dd3_reg;
            doc4_reg    <= doc3_reg;
            ococ4_reg   <= ococ3_reg;

            a5_reg   <= rci_pkg::sub_sat(dd4_reg, dvdv4_reg);
            b5_reg   <= rci_pkg::dbl_sat(rci_pkg::sub_sat(doc4_reg, dvocv4_reg));
            c5_reg   <= rci_pkg::sub_sat(rci_pkg::sub_sat(ococ4_reg, ocvocv4_reg),
                                         rci_pkg::word_t'(cfg.r2));
            ocv5_reg <= ocv4_reg;

            bb6_reg  <= rci_pkg::fmul(b5_reg, b5_reg);
            ac6_reg  <= rci_pkg::fmul(a5_reg, c5_reg);
            a6_reg   <= a5_reg;
            b6_reg   <= b5_reg;
            ocv6_reg <= ocv5_reg;

            disc7_reg   <= disc_next;
            den7_reg    <= rci_pkg::dbl_sat(a6_reg);
            nb7_reg     <= rci_pkg::neg_sat(b6_reg);
            noroot7_reg <= (disc_next < 0) || (a6_reg == 0);
            ocv7_reg    <= ocv6_reg;
        end
    end

    assign out_valid   = v_reg[NS-1];
    assign quad.ray    = ray_reg[NS-1];
    assign quad.ocv    = ocv7_reg;
    assign quad.nb     = nb7_reg;
    assign quad.den    = den7_reg;
    assign quad.noroot = noroot7_reg;
    assign disc        = disc7_reg;

endmodule

// ===== design/rci_surface.sv =====
// seven stage back end: hit point, axis projection and unnormalized
// normal with its squared length; depends on rci_pkg
module rci_surface (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rci_pkg::sel_t   sel,
    input  rci_pkg::cfg_t   cfg,
    output logic            out_valid,
    output rci_pkg::surf_t  surf,
    output rci_pkg::word_t  lensq
);

    localparam int NS = 7;

    logic [NS-1:0]  v_reg;
    logic           hit_reg [NS];
    rci_pkg::word_t t_reg [NS];
    rci_pkg::ray_t  ray1_reg;
    rci_pkg::word_t ocv1_reg, ocv2_reg;
    rci_pkg::word_t axv [3];
    rci_pkg::word_t cv [3];
    rci_pkg::word_t din [3];
    rci_pkg::word_t d1 [3];
    rci_pkg::word_t o1 [3];
    rci_pkg::word_t pdt_reg [3];
    rci_pkg::word_t axt_reg [3];
    logic signed [rci_pkg::PW-1:0] pm_reg [3];
    logic signed [rci_pkg::PW-1:0] pnn_reg [3];
    rci_pkg::word_t pos_reg [6][3];
    rci_pkg::word_t pc_reg [2][3];
    rci_pkg::word_t m_reg;
    rci_pkg::word_t am_reg [3];
    rci_pkg::word_t nrm_reg [3][3];
    rci_pkg::word_t lensq_reg;

    always_comb
    begin
        axv[0] = rci_pkg::axis_w(cfg.ax);
        axv[1] = rci_pkg::axis_w(cfg.ay);
        axv[2] = rci_pkg::axis_w(cfg.az);
        cv[0]  = cfg.cx;
        cv[1]  = cfg.cy;
        cv[2]  = cfg.cz;
        din[0] = sel.ray.dx;
        din[1] = sel.ray.dy;
        din[2] = sel.ray.dz;
        d1[0]  = ray1_reg.dx;
        d1[1]  = ray1_reg.dy;
        d1[2]  = ray1_reg.dz;
        o1[0]  = ray1_reg.ox;
        o1[1]  = ray1_reg.oy;
        o1[2]  = ray1_reg.oz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg[0] <= sel.hit;
            t_reg[0]   <= sel.t;
            for (int i = 1; i < NS; i++) begin
                hit_reg[i] <= hit_reg[i-1];
                t_reg[i]   <= t_reg[i-1];
            end
            ray1_reg <= sel.ray;
            ocv1_reg <= sel.ocv;
            ocv2_reg <= ocv1_reg;
            for (int k = 0; k < 3; k++) begin
                pdt_reg[k] <= rci_pkg::fmul(din[k], sel.t);
                axt_reg[k] <= rci_pkg::fmul(axv[k], sel.t);
            end
            for (int k = 0; k < 3; k++) begin
                pos_reg[0][k] <= rci_pkg::add_sat(o1[k], pdt_reg[k]);
                pm_reg[k]     <= rci_pkg::pshift(d1[k], axt_reg[k]);
            end
            for (int i = 1; i < 6; i++) begin
                for (int k = 0; k < 3; k++) begin
                    pos_reg[i][k] <= pos_reg[i-1][k];
                end
            end
            // projection of the hit point on the axis
            m_reg <= rci_pkg::add_sat(rci_pkg::dot3(pm_reg[0], pm_reg[1], pm_reg[2]),
                                      ocv2_reg);
            for (int k = 0; k < 3; k++) begin
                pc_reg[0][k]  <= rci_pkg::sub_sat(pos_reg[0][k], cv[k]);
                pc_reg[1][k]  <= pc_reg[0][k];
                am_reg[k]     <= rci_pkg::fmul(axv[k], m_reg);
                nrm_reg[0][k] <= rci_pkg::sub_sat(pc_reg[1][k], am_reg[k]);
                nrm_reg[1][k] <= nrm_reg[0][k];
                nrm_reg[2][k] <= nrm_reg[1][k];
                pnn_reg[k]    <= rci_pkg::pshift(nrm_reg[0][k], nrm_reg[0][k]);
            end
            lensq_reg <= rci_pkg::dot3(pnn_reg[0], pnn_reg[1], pnn_reg[2]);
        end
    end

    assign out_valid = v_reg[NS-1];
    assign surf.hit  = hit_reg[NS-1];
    assign surf.t    = t_reg[NS-1];
    assign surf.px   = pos_reg[5][0];
    assign surf.py   = pos_reg[5][1];
    assign surf.pz   = pos_reg[5][2];
    assign surf.nx   = nrm_reg[2][0];
    assign surf.ny   = nrm_reg[2][1];
    assign surf.nz   = nrm_reg[2][2];
    assign lensq     = lensq_reg;

endmodule

// ===== design/ray_cylinder_intersect_core.sv =====
// Ray versus infinite cylinder intersection, fully pipelined. One ray word
// is taken every cycle while the output is not stalled. It passes through
// 7 setup stages, a square root unit and a root divider, 7 hit point
// stages, a second square root unit and the normal dividers, each root or
// quotient unit resolving two bits per stage. A stall on the output freezes
// the whole pipeline; the output register holds a result while the next
// ray waits in the stages behind it. Cylinder registers are written through
// cfg_write/cfg_index/cfg_data and should change only while no ray is in
// flight. A ray parallel to the axis, or one with no root strictly inside
// (t_min, t_max), returns hit low with every other field zero.
// depends on rci_pkg, rci_quad, rci_sqrt_pipe, rci_div_pipe, rci_surface
`include "assert_macros.svh"

module ray_cylinder_intersect_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] origin_x,
    input  logic [31:0] origin_y,
    input  logic [31:0] origin_z,
    input  logic [31:0] dir_x,
    input  logic [31:0] dir_y,
    input  logic [31:0] dir_z,
    input  logic [31:0] t_min,
    input  logic [31:0] t_max,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [31:0] hit_t,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] pos_z,
    output logic [17:0] normal_x,
    output logic [17:0] normal_y,
    output logic [17:0] normal_z,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SQ = rci_pkg::SQRT_STAGES;
    localparam int DV = rci_pkg::DIV_STAGES;

    logic            en;
    rci_pkg::cfg_t   cfg_reg;
    rci_pkg::ray_t   ray_in;

    // setup stages
    logic            quad_valid;
    rci_pkg::quad_t  quad;
    rci_pkg::word_t  disc;

    // first square root and its side line
    logic [rci_pkg::SQRT_ROOT_W-1:0] s1_root;
    rci_pkg::quad_t  qd_reg [SQ];
    logic [SQ-1:0]   qv_reg;

    // numerator stage
    rci_pkg::quad_t  nq_reg;
    logic            nv_reg;
    rci_pkg::word_t  num0_reg, num1_reg;

    // root dividers and their side line
    logic [rci_pkg::DIV_N_W-1:0] q0, q1;
    logic            n0, n1;
    rci_pkg::quad_t  dq_reg [DV];
    logic [DV-1:0]   dv_reg;

    // root select
    rci_pkg::word_t  r0, r1;
    logic            f0, f1;
    rci_pkg::sel_t   sel_next;
    rci_pkg::sel_t   sel_reg;
    logic            selv_reg;

    // hit point stages
    logic            surf_valid;
    rci_pkg::surf_t  surf;
    rci_pkg::word_t  lensq;

    // second square root and its side line
    logic [rci_pkg::SQRT_ROOT_W-1:0] s2_root;
    rci_pkg::surf_t  sd_reg [SQ];
    logic [SQ-1:0]   sv_reg;

    // length stage
    rci_pkg::surf_t  lt_reg;
    rci_pkg::word_t  len_reg;
    logic            lz_reg;
    logic            lv_reg;

    // normal dividers and their side line
    logic [rci_pkg::DIV_N_W-1:0] qx, qy, qz;
    logic            nxs, nys, nzs;
    rci_pkg::surf_t  ld_reg [DV];
    logic [DV-1:0]   lzd_reg;
    logic [DV-1:0]   ldv_reg;

    // output register
    logic            out_valid_reg;
    logic            hit_reg;
    rci_pkg::word_t  hit_t_reg, pos_x_reg, pos_y_reg, pos_z_reg;
    rci_pkg::axis_t  normal_x_reg, normal_y_reg, normal_z_reg;

    // the whole pipeline advances unless a finished word is held
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        ray_in.ox  = origin_x;
        ray_in.oy  = origin_y;
        ray_in.oz  = origin_z;
        ray_in.dx  = dir_x;
        ray_in.dy  = dir_y;
        ray_in.dz  = dir_z;
        ray_in.tlo = t_min;
        ray_in.thi = t_max;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ax <= '0;
            cfg_reg.ay <= 18'(1 << rci_pkg::FRAC_BITS);
            cfg_reg.az <= '0;
            cfg_reg.cx <= '0;
            cfg_reg.cy <= '0;
            cfg_reg.cz <= '0;
            cfg_reg.r2 <= 31'(1 << rci_pkg::FRAC_BITS);
        end
        else if (cfg_write)
        begin
            case (rci_pkg::reg_index_t'(cfg_index))
                rci_pkg::REG_AXIS_X:    cfg_reg.ax <= cfg_data[17:0];
                rci_pkg::REG_AXIS_Y:    cfg_reg.ay <= cfg_data[17:0];
                rci_pkg::REG_AXIS_Z:    cfg_reg.az <= cfg_data[17:0];
                rci_pkg::REG_CENTER_X:  cfg_reg.cx <= cfg_data;
                rci_pkg::REG_CENTER_Y:  cfg_reg.cy <= cfg_data;
                rci_pkg::REG_CENTER_Z:  cfg_reg.cz <= cfg_data;
                rci_pkg::REG_RADIUS_SQ: cfg_reg.r2 <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    rci_quad u_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .ray       (ray_in),
        .cfg       (cfg_reg),
        .out_valid (quad_valid),
        .quad      (quad),
        .disc      (disc)
    );

    rci_sqrt_pipe u_sqrt_disc (
        .clk  (clk),
        .en   (en),
        .arg  (rci_pkg::sqrt_arg(disc)),
        .root (s1_root)
    );

    rci_div_pipe u_div_near (
        .clk  (clk),
        .en   (en),
        .num  (num0_reg),
        .den  (nq_reg.den),
        .quot (q0),
        .neg  (n0)
    );

    rci_div_pipe u_div_far (
        .clk  (clk),
        .en   (en),
        .num  (num1_reg),
        .den  (nq_reg.den),
        .quot (q1),
        .neg  (n1)
    );

    // near root wins when both lie inside the interval
    always_comb
    begin
        r0           = rci_pkg::sat32(rci_pkg::quot_signed(q0, n0));
        r1           = rci_pkg::sat32(rci_pkg::quot_signed(q1, n1));
        f0           = (r0 < dq_reg[DV-1].ray.thi) && (r0 > dq_reg[DV-1].ray.tlo);
        f1           = (r1 < dq_reg[DV-1].ray.thi) && (r1 > dq_reg[DV-1].ray.tlo);
        sel_next.ray = dq_reg[DV-1].ray;
        sel_next.ocv = dq_reg[DV-1].ocv;
        sel_next.hit = !dq_reg[DV-1].noroot && (f0 || f1);
        sel_next.t   = f0 ? r0 : r1;
    end

    rci_surface u_surface (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (selv_reg),
        .sel       (sel_reg),
        .cfg       (cfg_reg),
        .out_valid (surf_valid),
        .surf      (surf),
        .lensq     (lensq)
    );

    rci_sqrt_pipe u_sqrt_len (
        .clk  (clk),
        .en   (en),
        .arg  (rci_pkg::sqrt_arg(lensq)),
        .root (s2_root)
    );

    rci_div_pipe u_div_nx (
        .clk  (clk),
        .en   (en),
        .num  (lt_reg.nx),
        .den  (len_reg),
        .quot (qx),
        .neg  (nxs)
    );

    rci_div_pipe u_div_ny (
        .clk  (clk),
        .en   (en),
        .num  (lt_reg.ny),
        .den  (len_reg),
        .quot (qy),
        .neg  (nys)
    );

    rci_div_pipe u_div_nz (
        .clk  (clk),
        .en   (en),
        .num  (lt_reg.nz),
        .den  (len_reg),
        .quot (qz),
        .neg  (nzs)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg        <= '0;
            nv_reg        <= 1'b0;
            dv_reg        <= '0;
            selv_reg      <= 1'b0;
            sv_reg        <= '0;
            lv_reg        <= 1'b0;
            ldv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            qv_reg        <= {qv_reg[SQ-2:0], quad_valid};
            nv_reg        <= qv_reg[SQ-1];
            dv_reg        <= {dv_reg[DV-2:0], nv_reg};
            selv_reg      <= dv_reg[DV-1];
            sv_reg        <= {sv_reg[SQ-2:0], surf_valid};
            lv_reg        <= sv_reg[SQ-1];
            ldv_reg       <= {ldv_reg[DV-2:0], lv_reg};
            out_valid_reg <= ldv_reg[DV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qd_reg[0] <= quad;
            for (int i = 1; i < SQ; i++) begin
                qd_reg[i] <= qd_reg[i-1];
            end

            nq_reg   <= qd_reg[SQ-1];
            num0_reg <= rci_pkg::sub_sat(qd_reg[SQ-1].nb, rci_pkg::word_t'(s1_root));
            num1_reg <= rci_pkg::add_sat(qd_reg[SQ-1].nb, rci_pkg::word_t'(s1_root));

            dq_reg[0] <= nq_reg;
            for (int i = 1; i < DV; i++) begin
                dq_reg[i] <= dq_reg[i-1];
            end

            sel_reg <= sel_next;

            sd_reg[0] <= surf;
            for (int i = 1; i < SQ; i++) begin
                sd_reg[i] <= sd_reg[i-1];
            end

            lt_reg  <= sd_reg[SQ-1];
            len_reg <= rci_pkg::word_t'(s2_root);
            lz_reg  <= (s2_root == '0);

            ld_reg[0]  <= lt_reg;
            lzd_reg[0] <= lz_reg;
            for (int i = 1; i < DV; i++) begin
                ld_reg[i]  <= ld_reg[i-1];
                lzd_reg[i] <= lzd_reg[i-1];
            end

            // a miss clears every field, a zero length clears the normal
            hit_reg      <= ld_reg[DV-1].hit;
            hit_t_reg    <= ld_reg[DV-1].hit ? ld_reg[DV-1].t  : '0;
            pos_x_reg    <= ld_reg[DV-1].hit ? ld_reg[DV-1].px : '0;
            pos_y_reg    <= ld_reg[DV-1].hit ? ld_reg[DV-1].py : '0;
            pos_z_reg    <= ld_reg[DV-1].hit ? ld_reg[DV-1].pz : '0;
            normal_x_reg <= (ld_reg[DV-1].hit && !lzd_reg[DV-1])
                            ? rci_pkg::clamp18(rci_pkg::quot_signed(qx, nxs)) : '0;
            normal_y_reg <= (ld_reg[DV-1].hit && !lzd_reg[DV-1])
                            ? rci_pkg::clamp18(rci_pkg::quot_signed(qy, nys)) : '0;
            normal_z_reg <= (ld_reg[DV-1].hit && !lzd_reg[DV-1])
                            ? rci_pkg::clamp18(rci_pkg::quot_signed(qz, nzs)) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_t     = hit_t_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign normal_x  = normal_x_reg;
    assign normal_y  = normal_y_reg;
    assign normal_z  = normal_z_reg;

    `ASSERT_SAME_CYCLE(a_miss_zero, out_valid && !hit, hit_t == 0 && pos_x == 0 && pos_y == 0 && pos_z == 0 && normal_x == 0 && normal_y == 0 && normal_z == 0, "miss word with nonzero fields")
    `ASSERT_SAME_CYCLE(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken while output stalled")
    `ASSERT_NEXT_CYCLE(a_stall_freezes, !en, $stable(selv_reg) && $stable(ldv_reg), "pipeline moved while stalled")

endmodule

// ===== tb/tb.sv =====
// testbench for ray_cylinder_intersect_core: own fixed point predictor of the
// cylinder hit, directed and random rays under several cylinder settings
// depends on rci_pkg and the core with its submodules
module tb;

    localparam int FB = 16;
    localparam int PIPE_DEPTH = 90;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam longint ONE = 64'sd65536;

    typedef struct packed {
        logic           hit;
        rci_pkg::word_t t;
        rci_pkg::word_t px;
        rci_pkg::word_t py;
        rci_pkg::word_t pz;
        rci_pkg::axis_t nx;
        rci_pkg::axis_t ny;
        rci_pkg::axis_t nz;
    } hit_rec_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max;
    logic hit;
    logic [31:0] hit_t, pos_x, pos_y, pos_z;
    logic [17:0] normal_x, normal_y, normal_z;
    logic cfg_write;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    // cylinder registers as the block should hold them
    longint cyl_ax, cyl_ay, cyl_az, cyl_cx, cyl_cy, cyl_cz, cyl_r2;

    hit_rec_t pending_hits[$];
    bit failed;
    bit quiet;
    int unsigned cycles;

    ray_cylinder_intersect_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint sat_w(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_n(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return sat_w((a * b) >>> FB);
    endfunction

    function automatic longint qdot(longint ax, longint ay, longint az,
                                    longint bx, longint by, longint bz);
        return sat_w(((ax * bx) >>> FB) + ((ay * by) >>> FB) + ((az * bz) >>> FB));
    endfunction

    function automatic longint qsqrt(longint x);
        longint unsigned v, r, b;
        if (x <= 0) return 0;
        v = longint'(x) << FB;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint qdiv(longint n, longint q);
        longint unsigned un, uq, r;
        un = longint'(n < 0 ? -n : n) << FB;
        uq = q < 0 ? -q : q;
        r = un / uq;
        return ((n < 0) != (q < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic hit_rec_t trace_ray(rci_pkg::ray_t r);
        hit_rec_t res;
        longint ox, oy, oz, dx, dy, dz, tlo, thi;
        longint ocx, ocy, ocz, dv, ocv, a, b, c, disc, s, den, t, nb, num, rt;
        longint px, py, pz, m, nx, ny, nz, len;
        bit found;
        res = '0;
        ox = r.ox; oy = r.oy; oz = r.oz;
        dx = r.dx; dy = r.dy; dz = r.dz;
        tlo = r.tlo; thi = r.thi;
        t = 0;
        found = 0;
        ocx = sat_w(ox - cyl_cx); ocy = sat_w(oy - cyl_cy); ocz = sat_w(oz - cyl_cz);
        dv = qdot(dx, dy, dz, cyl_ax, cyl_ay, cyl_az);
        ocv = qdot(ocx, ocy, ocz, cyl_ax, cyl_ay, cyl_az);
        a = sat_w(qdot(dx, dy, dz, dx, dy, dz) - qmul(dv, dv));
        b = sat_w(2 * sat_w(qdot(dx, dy, dz, ocx, ocy, ocz) - qmul(dv, ocv)));
        c = sat_w(sat_w(qdot(ocx, ocy, ocz, ocx, ocy, ocz) - qmul(ocv, ocv)) - cyl_r2);
        disc = sat_w(qmul(b, b) - sat_w(4 * qmul(a, c)));
        if (disc < 0 || a == 0) return res;
        s = qsqrt(disc);
        den = sat_w(2 * a);
        nb = sat_w(-b);
        for (int k = 0; k < 2 && !found; k++)
        begin
            num = (k == 0) ? sat_w(nb - s) : sat_w(nb + s);
            rt = sat_w(qdiv(num, den));
            if (rt < thi && rt > tlo)
            begin
                t = rt;
                found = 1;
            end
        end
        if (!found) return res;
        px = sat_w(ox + qmul(dx, t));
        py = sat_w(oy + qmul(dy, t));
        pz = sat_w(oz + qmul(dz, t));
        m = sat_w(qdot(dx, dy, dz, qmul(cyl_ax, t), qmul(cyl_ay, t), qmul(cyl_az, t)) + ocv);
        nx = sat_w(sat_w(px - cyl_cx) - qmul(cyl_ax, m));
        ny = sat_w(sat_w(py - cyl_cy) - qmul(cyl_ay, m));
        nz = sat_w(sat_w(pz - cyl_cz) - qmul(cyl_az, m));
        len = qsqrt(qdot(nx, ny, nz, nx, ny, nz));
        res.hit = 1'b1;
        res.t = rci_pkg::word_t'(t);
        res.px = rci_pkg::word_t'(px);
        res.py = rci_pkg::word_t'(py);
        res.pz = rci_pkg::word_t'(pz);
        if (len != 0)
        begin
            res.nx = rci_pkg::axis_t'(clamp_n(qdiv(nx, len)));
            res.ny = rci_pkg::axis_t'(clamp_n(qdiv(ny, len)));
            res.nz = rci_pkg::axis_t'(clamp_n(qdiv(nz, len)));
        end
        return res;
    endfunction

    // ---------------- checking ----------------
    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
            failed = 1;
        end
    endtask

    // expected fields are compared as raw bits, zero extended like the ports
    always @(posedge clk)
    begin
        hit_rec_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%0t unexpected result word: expected none actual hit %b t %h",
                         $time, hit, hit_t);
                failed = 1;
            end
            else
            begin
                e = pending_hits.pop_front();
                check_field("hit", e.hit, hit);
                check_field("hit_t", $unsigned(e.t), hit_t);
                check_field("pos_x", $unsigned(e.px), pos_x);
                check_field("pos_y", $unsigned(e.py), pos_y);
                check_field("pos_z", $unsigned(e.pz), pos_z);
                check_field("normal_x", $unsigned(e.nx), normal_x);
                check_field("normal_y", $unsigned(e.ny), normal_y);
                check_field("normal_z", $unsigned(e.nz), normal_z);
            end
        end
    end

    // output back-pressure in short bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    // ---------------- drivers ----------------
    task automatic send_ray(rci_pkg::ray_t r);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        origin_x = r.ox; origin_y = r.oy; origin_z = r.oz;
        dir_x = r.dx; dir_y = r.dy; dir_z = r.dz;
        t_min = r.tlo; t_max = r.thi;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_hits.push_back(trace_ray(r));
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            rci_pkg::REG_AXIS_X:    cyl_ax = longint'($signed(data[17:0]));
            rci_pkg::REG_AXIS_Y:    cyl_ay = longint'($signed(data[17:0]));
            rci_pkg::REG_AXIS_Z:    cyl_az = longint'($signed(data[17:0]));
            rci_pkg::REG_CENTER_X:  cyl_cx = longint'($signed(data));
            rci_pkg::REG_CENTER_Y:  cyl_cy = longint'($signed(data));
            rci_pkg::REG_CENTER_Z:  cyl_cz = longint'($signed(data));
            rci_pkg::REG_RADIUS_SQ: cyl_r2 = longint'(data[30:0]);
            default: ;
        endcase
    endtask

    task automatic set_cylinder(longint ax, longint ay, longint az,
                                longint cx, longint cy, longint cz, longint r2);
        write_reg(rci_pkg::REG_AXIS_X, 32'(ax));
        write_reg(rci_pkg::REG_AXIS_Y, 32'(ay));
        write_reg(rci_pkg::REG_AXIS_Z, 32'(az));
        write_reg(rci_pkg::REG_CENTER_X, 32'(cx));
        write_reg(rci_pkg::REG_CENTER_Y, 32'(cy));
        write_reg(rci_pkg::REG_CENTER_Z, 32'(cz));
        write_reg(rci_pkg::REG_RADIUS_SQ, 32'(r2));
    endtask

    function automatic rci_pkg::ray_t make_ray(longint ox, longint oy, longint oz,
                                               longint dx, longint dy, longint dz,
                                               longint tlo, longint thi);
        rci_pkg::ray_t r;
        r.ox = ox; r.oy = oy; r.oz = oz;
        r.dx = dx; r.dy = dy; r.dz = dz;
        r.tlo = tlo; r.thi = thi;
        return r;
    endfunction

    function automatic rci_pkg::word_t rand_near(int span);
        longint v;
        v = longint'($urandom_range(0, span)) * ONE + $urandom_range(0, 65535);
        return rci_pkg::word_t'($urandom_range(0, 1) ? -v : v);
    endfunction

    function automatic rci_pkg::ray_t rand_ray();
        rci_pkg::ray_t r;
        if ($urandom_range(0, 6) == 0)
        begin
            // noise: every bit free
            r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
            r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
            r.tlo = $urandom; r.thi = $urandom;
            return r;
        end
        r.ox = rand_near(6) + rci_pkg::word_t'(cyl_cx);
        r.oy = rand_near(6) + rci_pkg::word_t'(cyl_cy);
        r.oz = rand_near(6) + rci_pkg::word_t'(cyl_cz);
        r.dx = rand_near(1); r.dy = rand_near(1); r.dz = rand_near(1);
        case ($urandom_range(0, 3))
            0: r.tlo = 0;
            1: r.tlo = -rand_near(3);
            2: r.tlo = rand_near(4);
            default: r.tlo = rci_pkg::word_t'(-64'sd2147483648);
        endcase
        r.thi = $urandom_range(0, 1)
                ? rci_pkg::word_t'(64'sd2147483647)
                : rci_pkg::word_t'(longint'($urandom_range(1, 40)) * ONE);
        return r;
    endfunction

    task automatic rand_cylinder();
        longint ax, ay, az, r2;
        ax = 0; ay = 0; az = 0;
        case ($urandom_range(0, 3))
            0: ax = $urandom_range(0, 1) ? ONE : -ONE;
            1: ay = $urandom_range(0, 1) ? ONE : -ONE;
            2: begin ax = 46341; az = $urandom_range(0, 1) ? 46341 : -46341; end
            default: begin
                ax = longint'($signed(18'($urandom)));
                ay = longint'($signed(18'($urandom)));
                az = longint'($signed(18'($urandom)));
            end
        endcase
        r2 = $urandom_range(0, 5) == 0 ? longint'($urandom & 32'h7fffffff)
                                       : longint'($urandom_range(0, 9)) * ONE;
        set_cylinder(ax, ay, az, rand_near(3), rand_near(3), rand_near(3), r2);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed;
        // default cylinder: y axis through origin, radius one
        send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 0, 100 * ONE));
        send_ray(make_ray(0, 3 * ONE, 0, ONE, 0, 0, 0, 100 * ONE));
        send_ray(make_ray(-5 * ONE, 0, 0, -ONE, 0, 0, -100 * ONE, 100 * ONE));
        // axis parallel ray
        send_ray(make_ray(0, 0, 0, 0, ONE, 0, -100 * ONE, 100 * ONE));
        // empty interval
        send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 10 * ONE, 10 * ONE));
        send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 20 * ONE, ONE));
        // miss
        send_ray(make_ray(-5 * ONE, 0, 3 * ONE, ONE, 0, 0, 0, 100 * ONE));
        // inside, far root wins; then an oblique ray from outside
        send_ray(make_ray(0, ONE, 0, 0, 0, ONE, 0, 100 * ONE));
        send_ray(make_ray(-5 * ONE, 2 * ONE, 0, ONE, ONE, 0, 0, 100 * ONE));
        // field extremes
        send_ray(make_ray(64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff,
                          64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff));
        send_ray(make_ray(-64'sh80000000, -64'sh80000000, -64'sh80000000, -64'sh80000000,
                          -64'sh80000000, -64'sh80000000, -64'sh80000000, 64'sh7fffffff));
        send_ray(make_ray(-64'sh80000000, 0, 0, ONE, 0, 0, -64'sh80000000, 64'sh7fffffff));
        drain();
        // zero radius, ray through the axis gives a zero length normal
        write_reg(rci_pkg::REG_RADIUS_SQ, 32'd0);
        send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 0, 100 * ONE));
        send_ray(make_ray(-5 * ONE, 7, 0, ONE, 0, 0, 0, 100 * ONE));
        drain();
    endtask

    task automatic test_extreme_cylinders;
        set_cylinder(-ONE, 0, 0, 64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff, 64'h7fffffff);
        write_reg(REG_UNUSED, 32'hffffffff);
        for (int i = 0; i < 20; i++) send_ray(rand_ray());
        send_ray(make_ray(0, 0, 0, 0, ONE, 0, 0, 64'sh7fffffff));
        drain();
        set_cylinder(0, 0, ONE, -64'sh80000000, -64'sh80000000, -64'sh80000000, 0);
        for (int i = 0; i < 20; i++) send_ray(rand_ray());
        drain();
        set_cylinder(64'sd131071, -64'sd131072, 0, 0, 0, 0, 4 * ONE);
        for (int i = 0; i < 20; i++) send_ray(rand_ray());
        drain();
    endtask

    task automatic test_random_rays;
        for (int p = 0; p < 7; p++)
        begin
            rand_cylinder();
            for (int i = 0; i < 70; i++) send_ray(rand_ray());
            drain();
        end
    endtask

    task automatic test_full_rate;
        quiet = 1;
        set_cylinder(0, ONE, 0, 0, 0, 0, ONE);
        for (int i = 0; i < 60; i++) send_ray(rand_ray());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_write = 1'b0;
        cfg_index = rci_pkg::REG_AXIS_X;
        cfg_data = '0;
        {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max} = '0;
        failed = 0;
        quiet = 0;
        cycles = 0;
        cyl_ax = 0; cyl_ay = ONE; cyl_az = 0;
        cyl_cx = 0; cyl_cy = 0; cyl_cz = 0;
        cyl_r2 = ONE;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_directed();
        test_extreme_cylinders();
        test_random_rays();
        test_full_rate();

        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
